// File: design/substring_removal_filter_macros.svh
// ----------------------------------------------------------------------------
// substring removal filter assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_REMOVAL_FILTER_MACROS_SVH
`define SUBSTRING_REMOVAL_FILTER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define SRF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srf assertion failed");

// consequent holds in the cycle after the antecedent
`define SRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srf assertion failed");

`endif

// File: design/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg
// shared constants, types and sequencer states of the substring removal filter
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

  localparam int MAX_PATTERN = 19;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
  localparam int TOTAL_W     = 16;
  localparam int CFG_W       = 64;
  localparam int IDX_W       = 2;
  localparam int LOW_W       = 64;
  localparam int MID_W       = 64;
  localparam int HIGH_W      = 24;

  localparam logic [IDX_W-1:0] REG_PAT_LEN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PAT_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_PAT_MID  = 2'd2;
  localparam logic [IDX_W-1:0] REG_PAT_HIGH = 2'd3;

  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_vec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_RECORD,
    S_CLOSE
  } state_t;

  typedef struct packed {
    logic is_prefix;
    logic is_full;
  } match_t;

endpackage

`default_nettype wire

// File: design/substring_removal_filter.sv
// ----------------------------------------------------------------------------
// substring_removal_filter
// removes every leftmost non-overlapping pattern occurrence from a byte stream
// ----------------------------------------------------------------------------
// usage:
//   program the pattern length and bytes through the cfg write port while the
//   block is idle; a length of zero passes the text through unchanged.
//   input transactions carry one text byte; end_of_text marks the last one.
//   each output transaction is a released text byte (kind 0) or, after the
//   last byte, one count record (kind 1) with the number of removed matches.
//   last_of_run flags the final output caused by an input transaction.
// timing:
//   one shared prefix compare unit judges the held bytes once per cycle. after
//   an input byte is taken, held bytes that cannot begin a match are released
//   one at a time; the last byte is followed by the count record, and when the
//   scan ends on a held prefix or a removed match a flush pass releases any
//   held bytes first. the block takes no input until its item is done.
//   output is registered behind a one-entry pending stage; a result moves on to
//   the output register when the next result or the close of its run follows.
// reset: synchronous active-low rst_n clears pattern, state, counts, valid flags.
// a stalled output holds its transaction and, with one pending, pauses releases.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_removal_filter (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [srf_pkg::IDX_W-1:0]        cfg_index,
  input  wire  [srf_pkg::CFG_W-1:0]        cfg_wr_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [srf_pkg::BYTE_W-1:0]       in_text_byte,
  input  wire                              in_end_of_text,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_result_kind,
  output logic [srf_pkg::BYTE_W-1:0]       out_kept_byte,
  output logic [srf_pkg::TOTAL_W-1:0]      out_match_count,
  output logic                             out_last_of_run
);

  // configuration
  srf_pkg::cnt_t               pat_len_r;
  logic [srf_pkg::LOW_W-1:0]   pat_low_r;
  logic [srf_pkg::MID_W-1:0]   pat_mid_r;
  logic [srf_pkg::HIGH_W-1:0]  pat_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r  <= '0;
      pat_low_r  <= '0;
      pat_mid_r  <= '0;
      pat_high_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srf_pkg::REG_PAT_LEN:  pat_len_r  <= cfg_wr_data[srf_pkg::CNT_W-1:0];
        srf_pkg::REG_PAT_LOW:  pat_low_r  <= cfg_wr_data[srf_pkg::LOW_W-1:0];
        srf_pkg::REG_PAT_MID:  pat_mid_r  <= cfg_wr_data[srf_pkg::MID_W-1:0];
        srf_pkg::REG_PAT_HIGH: pat_high_r <= cfg_wr_data[srf_pkg::HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  srf_pkg::byte_vec_t pattern;
  srf_pkg::cnt_t      eff_len;

  assign pattern = srf_pkg::byte_vec_t'({pat_high_r, pat_mid_r, pat_low_r});
  // lengths above the buffer depth are clamped
  assign eff_len = (pat_len_r > srf_pkg::cnt_t'(srf_pkg::MAX_PATTERN)) ?
                   srf_pkg::cnt_t'(srf_pkg::MAX_PATTERN) : pat_len_r;

  // state
  srf_pkg::state_t              state_r, state_nxt;
  srf_pkg::byte_vec_t           held_r;
  srf_pkg::cnt_t                count_r, count_nxt;
  logic [srf_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic                         last_r;

  logic                         pend_valid_r;
  logic                         pend_kind_r;
  logic [srf_pkg::BYTE_W-1:0]   pend_byte_r;
  logic [srf_pkg::TOTAL_W-1:0]  pend_count_r;

  logic                         out_valid_r;
  logic                         out_kind_r;
  logic [srf_pkg::BYTE_W-1:0]   out_byte_r;
  logic [srf_pkg::TOTAL_W-1:0]  out_count_r;
  logic                         out_last_r;

  srf_pkg::match_t match;

  srf_cmp u_cmp (
    .held    (held_r),
    .pattern (pattern),
    .count   (count_r),
    .len     (eff_len),
    .result  (match)
  );

  logic prefix_ok;
  logic out_free;
  logic slot_ok;
  logic do_accept;
  logic do_release;
  logic do_match;
  logic do_record;
  logic do_close;
  logic produce;
  logic pend_to_out;

  assign prefix_ok = (eff_len != '0) && match.is_prefix;
  assign out_free  = !out_valid_r || !out_stall;
  assign slot_ok   = !pend_valid_r || out_free;

  // sequencer actions
  always_comb begin
    do_accept  = 1'b0;
    do_release = 1'b0;
    do_match   = 1'b0;
    do_record  = 1'b0;
    do_close   = 1'b0;
    case (state_r)
      srf_pkg::S_IDLE: begin
        do_accept = in_valid;
      end
      srf_pkg::S_SCAN: begin
        if (count_r != '0) begin
          if (prefix_ok) begin
            do_match = match.is_full;
          end else begin
            do_release = slot_ok;
          end
        end
      end
      srf_pkg::S_FLUSH: begin
        do_release = (count_r != '0) && slot_ok;
      end
      srf_pkg::S_RECORD: begin
        do_record = slot_ok;
      end
      srf_pkg::S_CLOSE: begin
        do_close = !pend_valid_r || out_free;
      end
      default: ;
    endcase
  end

  assign produce     = do_release || do_record;
  assign pend_to_out = pend_valid_r && (produce || do_close);
  assign in_stall    = (state_r != srf_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srf_pkg::S_IDLE: begin
        if (in_valid) state_nxt = srf_pkg::S_SCAN;
      end
      srf_pkg::S_SCAN: begin
        if (count_r == '0) begin
          state_nxt = last_r ? srf_pkg::S_RECORD : srf_pkg::S_CLOSE;
        end else if (prefix_ok) begin
          state_nxt = last_r ? srf_pkg::S_FLUSH : srf_pkg::S_CLOSE;
        end
      end
      srf_pkg::S_FLUSH: begin
        if (count_r == '0) state_nxt = srf_pkg::S_RECORD;
      end
      srf_pkg::S_RECORD: begin
        if (slot_ok) state_nxt = srf_pkg::S_CLOSE;
      end
      srf_pkg::S_CLOSE: begin
        if (do_close) state_nxt = srf_pkg::S_IDLE;
      end
      default: state_nxt = srf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_accept) begin
      count_nxt = count_r + 1'b1;
    end else if (do_release) begin
      count_nxt = count_r - 1'b1;
    end else if (do_match || do_record) begin
      count_nxt = '0;
    end
  end

  always_comb begin
    total_nxt = total_r;
    if (do_match && (total_r != '1)) begin
      total_nxt = total_r + 1'b1;
    end else if (do_record) begin
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srf_pkg::S_IDLE;
      count_r <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  // held bytes: append at the fill point, shift down on release
  always_ff @(posedge clk) begin
    if (do_accept) begin
      held_r[count_r] <= in_text_byte;
      last_r          <= in_end_of_text;
    end else if (do_release) begin
      for (int i = 0; i < srf_pkg::MAX_PATTERN - 1; i++) begin
        held_r[i] <= held_r[i+1];
      end
    end
  end

  // pending stage: a result waits here until it is known whether it ends the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (produce) begin
      pend_valid_r <= 1'b1;
    end else if (pend_to_out) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      pend_kind_r  <= do_record ? srf_pkg::KIND_COUNT : srf_pkg::KIND_TEXT;
      pend_byte_r  <= do_record ? '0 : held_r[0];
      pend_count_r <= total_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_to_out) begin
      out_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_to_out) begin
      out_kind_r  <= pend_kind_r;
      out_byte_r  <= pend_byte_r;
      out_count_r <= pend_count_r;
      out_last_r  <= do_close;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_kept_byte   = out_byte_r;
  assign out_match_count = out_count_r;
  assign out_last_of_run = out_last_r;

  `include "substring_removal_filter_macros.svh"

  `SRF_ASSERT_SAME(a_count_bound, 1'b1, count_r <= srf_pkg::cnt_t'(srf_pkg::MAX_PATTERN))
  `SRF_ASSERT_NEXT(a_accept_scans, do_accept, state_r == srf_pkg::S_SCAN)
  `SRF_ASSERT_SAME(a_record_zero_byte, out_valid_r && out_kind_r, out_byte_r == '0)
  `SRF_ASSERT_NEXT(a_record_clears, do_record, (total_r == '0) && (count_r == '0))
  `SRF_ASSERT_NEXT(a_close_drains, do_close, !pend_valid_r && (state_r == srf_pkg::S_IDLE))

endmodule

`default_nettype wire

// File: design/srf_cmp.sv
// ----------------------------------------------------------------------------
// srf_cmp
// prefix compare unit: checks the held bytes against the head of the pattern
// ----------------------------------------------------------------------------
`default_nettype none

module srf_cmp (
  input  wire srf_pkg::byte_vec_t held,
  input  wire srf_pkg::byte_vec_t pattern,
  input  wire srf_pkg::cnt_t      count,
  input  wire srf_pkg::cnt_t      len,
  output srf_pkg::match_t         result
);

  logic [srf_pkg::MAX_PATTERN-1:0] miss;

  always_comb begin
    for (int i = 0; i < srf_pkg::MAX_PATTERN; i++) begin
      // only entries below the fill count take part
      miss[i] = (srf_pkg::cnt_t'(i) < count) && (held[i] != pattern[i]);
    end
  end

  assign result.is_prefix = (count <= len) && (miss == '0);
  assign result.is_full   = (count == len);

endmodule

`default_nettype wire
